// ===== design/bfs_augmenting_max_flow_unit_defines.svh =====
// Assertion macros shared by the max-flow unit RTL
`ifndef BFS_AUGMENTING_MAX_FLOW_UNIT_DEFINES_SVH
`define BFS_AUGMENTING_MAX_FLOW_UNIT_DEFINES_SVH

// same-cycle implication
`define BFSMF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BFSMF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/bfsmf_pkg.sv =====
// Shared types and constants of the max-flow unit
package bfsmf_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_CAP_BITS  = 16;
    localparam int NODE_FW       = 6;
    localparam int CAP_FW        = 16;
    localparam int NC_W          = 7;
    localparam int CFG_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int TOTAL_W       = 22;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3FFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINK       = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2,
        DIR_SRC  = 2'd3
    } dir_t;

    typedef enum logic [4:0] {
        ST_CLR_CAP,
        ST_IDLE,
        ST_CLR_FLOW,
        ST_CHECK_CFG,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_LBL_WAIT,
        ST_SCAN_FWD,
        ST_SCAN_BWD,
        ST_SCAN_END,
        ST_SINK_CHK,
        ST_AUG_START,
        ST_AUG_NECK,
        ST_AUG_STEP,
        ST_AUG_LBL,
        ST_AUG_FLOW,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic cap_clr;
        logic flow_clr;
        logic total_clr;
        logic search_init;
        logic pop;
        logic take_u;
        logic take_neck_u;
        logic scan_issue;
        logic scan_bwd;
        logic aug_start;
        logic take_neck;
        logic aug_flow_rd;
        logic aug_flow_wr;
        logic total_add;
        logic result;
    } ctl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic cfg_ok;
        logic queue_empty;
        logic scan_last;
        logic sink_found;
        logic aug_done;
        logic out_busy;
    } ctl_sts_t;

endpackage

// ===== design/bfsmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bfsmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bfsmf_ctrl.sv =====
// Sequencer of the max-flow unit: clearing, search, augmentation, result
module bfsmf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    input  bfsmf_pkg::ctl_sts_t sts,
    output bfsmf_pkg::ctl_cmd_t cmd
);
    import bfsmf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_CAP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLR_CAP: begin
                cmd.cap_clr = 1'b1;
                if (sts.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == CMD_RUN) begin
                        cmd.total_clr = 1'b1;
                        state_next    = ST_CLR_FLOW;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CLR_FLOW: begin
                cmd.flow_clr = 1'b1;
                if (sts.sweep_last) state_next = ST_CHECK_CFG;
            end
            ST_CHECK_CFG: begin
                state_next = sts.cfg_ok ? ST_INIT : ST_DONE;
            end
            ST_INIT: begin
                cmd.search_init = 1'b1;
                state_next      = ST_POP;
            end
            ST_POP: begin
                if (sts.queue_empty) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                cmd.take_u = 1'b1;
                state_next = ST_LBL_WAIT;
            end
            ST_LBL_WAIT: begin
                cmd.take_neck_u = 1'b1;
                state_next      = ST_SCAN_FWD;
            end
            ST_SCAN_FWD: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) state_next = ST_SCAN_BWD;
            end
            ST_SCAN_BWD: begin
                cmd.scan_issue = 1'b1;
                cmd.scan_bwd   = 1'b1;
                if (sts.scan_last) state_next = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                state_next = ST_SINK_CHK;
            end
            ST_SINK_CHK: begin
                state_next = sts.sink_found ? ST_AUG_START : ST_POP;
            end
            ST_AUG_START: begin
                cmd.aug_start = 1'b1;
                state_next    = ST_AUG_NECK;
            end
            ST_AUG_NECK: begin
                cmd.take_neck = 1'b1;
                state_next    = ST_AUG_STEP;
            end
            ST_AUG_STEP: begin
                if (sts.aug_done) begin
                    state_next = ST_ADD;
                end else begin
                    state_next = ST_AUG_LBL;
                end
            end
            ST_AUG_LBL: begin
                cmd.aug_flow_rd = 1'b1;
                state_next      = ST_AUG_FLOW;
            end
            ST_AUG_FLOW: begin
                cmd.aug_flow_wr = 1'b1;
                state_next      = ST_AUG_STEP;
            end
            ST_ADD: begin
                cmd.total_add = 1'b1;
                state_next    = ST_INIT;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLR_CAP;
            end
        endcase
    end

endmodule

// ===== design/bfsmf_dp.sv =====
// Datapath of the max-flow unit: matrices, labels, queue, flow total
`include "bfs_augmenting_max_flow_unit_defines.svh"
module bfsmf_dp #(
    parameter int MAX_NODES = bfsmf_pkg::DEF_MAX_NODES,
    parameter int CAP_BITS  = bfsmf_pkg::DEF_CAP_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bfsmf_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [bfsmf_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [bfsmf_pkg::NODE_FW-1:0]       from_node,
    input  logic [bfsmf_pkg::NODE_FW-1:0]       to_node,
    input  logic [bfsmf_pkg::CAP_FW-1:0]        capacity,
    input  bfsmf_pkg::ctl_cmd_t                 cmd,
    output bfsmf_pkg::ctl_sts_t                 sts,
    input  logic                                m_tready,
    output logic                                m_valid,
    output logic [bfsmf_pkg::TOTAL_W-1:0]       total_out
);
    import bfsmf_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = 2 * NW;
    localparam int NKW = CAP_BITS + 1;
    localparam int LW  = 2 + NW + NKW;
    localparam int QW  = NW + 1;
    localparam int SW  = ((TOTAL_W > NKW) ? TOTAL_W : NKW) + 1;

    logic [NC_W-1:0]    node_count_reg;
    logic [NODE_FW-1:0] source_reg;
    logic [NODE_FW-1:0] sink_reg;

    logic [AW-1:0]      sweep_reg;
    logic [QW-1:0]      head_reg;
    logic [QW-1:0]      tail_reg;
    logic [MAX_NODES-1:0] labelled_reg;
    logic [NW-1:0]      u_reg;
    logic [NKW-1:0]     neck_u_reg;
    logic [NW-1:0]      v_reg;
    logic               eval_vld_reg;
    logic               eval_bwd_reg;
    logic [NW-1:0]      eval_v_reg;
    logic [NW-1:0]      cur_reg;
    logic [NW:0]        steps_reg;
    logic [NKW-1:0]     neck_reg;
    logic               aug_fwd_reg;
    logic [NW-1:0]      parent_reg;
    logic [AW-1:0]      aug_addr_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] result_reg;
    logic               m_valid_reg;

    logic [8:0]         nc9;
    logic [8:0]         n_eff;
    logic [NW-1:0]      s_node;
    logic [NW-1:0]      t_node;
    logic [CAP_BITS-1:0] cap_in;
    logic               load_ok;

    logic               cap_we;
    logic [AW-1:0]      cap_waddr;
    logic [CAP_BITS-1:0] cap_wdata;
    logic [CAP_BITS-1:0] cap_rdata;
    logic               flow_we;
    logic [AW-1:0]      flow_waddr;
    logic [CAP_BITS-1:0] flow_wdata;
    logic [AW-1:0]      flow_raddr;
    logic [CAP_BITS-1:0] flow_rdata;
    logic [AW-1:0]      scan_addr;
    logic [AW-1:0]      aug_rd_addr;

    logic               lbl_we;
    logic [NW-1:0]      lbl_waddr;
    logic [LW-1:0]      lbl_wdata;
    logic [NW-1:0]      lbl_raddr;
    logic [LW-1:0]      lbl_rdata;
    dir_t               lbl_dir;
    logic [NW-1:0]      lbl_parent;
    logic [NKW-1:0]     lbl_neck;

    logic               q_we;
    logic [NW-1:0]      q_waddr;
    logic [NW-1:0]      q_wdata;
    logic [NW-1:0]      q_rdata;

    logic               fwd_ok;
    logic               bwd_ok;
    logic               mark_en;
    logic               q_room;
    logic [NKW-1:0]     cand;
    logic [NKW-1:0]     mark_neck;
    logic [SW-1:0]      sum;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NC_W'(64);
            source_reg     <= '0;
            sink_reg       <= NODE_FW'(63);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NODE_COUNT: node_count_reg <= cfg_wdata[NC_W-1:0];
                REG_SOURCE:     source_reg     <= cfg_wdata[NODE_FW-1:0];
                REG_SINK:       sink_reg       <= cfg_wdata[NODE_FW-1:0];
                default:        ;
            endcase
        end
    end

    assign nc9    = 9'(node_count_reg);
    assign n_eff  = (nc9 > 9'(MAX_NODES)) ? 9'(MAX_NODES) : nc9;
    assign s_node = NW'(source_reg);
    assign t_node = NW'(sink_reg);
    assign cap_in = CAP_BITS'(capacity);
    assign load_ok = (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);

    // label entry fields
    assign lbl_dir    = dir_t'(lbl_rdata[LW-1 -: 2]);
    assign lbl_parent = lbl_rdata[NKW +: NW];
    assign lbl_neck   = lbl_rdata[NKW-1:0];

    // scan evaluation
    assign fwd_ok  = (cap_rdata != '0) && !labelled_reg[eval_v_reg] && (flow_rdata < cap_rdata);
    assign bwd_ok  = (cap_rdata != '0) && !labelled_reg[eval_v_reg] && (flow_rdata != '0);
    assign mark_en = eval_vld_reg && (eval_bwd_reg ? bwd_ok : fwd_ok);
    assign q_room  = tail_reg < QW'(MAX_NODES);
    assign cand    = eval_bwd_reg ? NKW'(flow_rdata) : NKW'(cap_rdata - flow_rdata);
    assign mark_neck = (neck_u_reg < cand) ? neck_u_reg : cand;

    assign scan_addr   = cmd.scan_bwd ? {v_reg, u_reg} : {u_reg, v_reg};
    assign aug_rd_addr = (lbl_dir == DIR_FWD) ? {lbl_parent, cur_reg} : {cur_reg, lbl_parent};

    // capacity store
    assign cap_we    = cmd.cap_clr || (cmd.load && load_ok);
    assign cap_waddr = cmd.cap_clr ? sweep_reg : {NW'(from_node), NW'(to_node)};
    assign cap_wdata = cmd.cap_clr ? '0 : cap_in;

    bfsmf_ram #(.WIDTH(CAP_BITS), .DEPTH(1 << AW)) u_cap_ram (
        .aclk  (aclk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (cap_wdata),
        .raddr (scan_addr),
        .rdata (cap_rdata)
    );

    // flow store
    assign flow_we    = cmd.flow_clr || cmd.aug_flow_wr;
    assign flow_waddr = cmd.flow_clr ? sweep_reg : aug_addr_reg;
    assign flow_wdata = cmd.flow_clr ? '0 :
                        aug_fwd_reg ? flow_rdata + neck_reg[CAP_BITS-1:0]
                                    : flow_rdata - neck_reg[CAP_BITS-1:0];
    assign flow_raddr = cmd.scan_issue ? scan_addr : aug_rd_addr;

    bfsmf_ram #(.WIDTH(CAP_BITS), .DEPTH(1 << AW)) u_flow_ram (
        .aclk  (aclk),
        .we    (flow_we),
        .waddr (flow_waddr),
        .wdata (flow_wdata),
        .raddr (flow_raddr),
        .rdata (flow_rdata)
    );

    // labels
    assign lbl_we    = cmd.search_init || mark_en;
    assign lbl_waddr = cmd.search_init ? s_node : eval_v_reg;
    assign lbl_wdata = cmd.search_init ? {DIR_SRC, s_node, NKW'(1) << CAP_BITS}
                     : {(eval_bwd_reg ? DIR_BWD : DIR_FWD), u_reg, mark_neck};
    assign lbl_raddr = cmd.take_u ? q_rdata : (cmd.aug_start ? t_node : cur_reg);

    bfsmf_ram #(.WIDTH(LW), .DEPTH(1 << NW)) u_lbl_ram (
        .aclk  (aclk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    // search queue
    assign q_we    = cmd.search_init || (mark_en && q_room);
    assign q_waddr = cmd.search_init ? '0 : tail_reg[NW-1:0];
    assign q_wdata = cmd.search_init ? s_node : eval_v_reg;

    bfsmf_ram #(.WIDTH(NW), .DEPTH(1 << NW)) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[NW-1:0]),
        .rdata (q_rdata)
    );

    assign sum = SW'(total_reg) + SW'(neck_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            labelled_reg <= '0;
            eval_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            total_reg    <= '0;
        end else begin
            if (cmd.cap_clr || cmd.flow_clr) sweep_reg <= sweep_reg + 1'b1;
            eval_vld_reg <= cmd.scan_issue;
            if (cmd.search_init) begin
                head_reg     <= '0;
                tail_reg     <= QW'(1);
                labelled_reg <= MAX_NODES'(1) << s_node;
            end else begin
                if (cmd.pop) head_reg <= head_reg + 1'b1;
                if (mark_en) begin
                    labelled_reg[eval_v_reg] <= 1'b1;
                    if (q_room) tail_reg <= tail_reg + 1'b1;
                end
            end
            if (cmd.total_clr) begin
                total_reg <= '0;
            end else if (cmd.total_add) begin
                total_reg <= (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
            end
            if (cmd.result) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        eval_bwd_reg <= cmd.scan_bwd;
        eval_v_reg   <= v_reg;
        if (cmd.result) result_reg <= total_reg;
        if (cmd.take_u) u_reg <= q_rdata;
        if (cmd.take_neck_u) neck_u_reg <= lbl_neck;
        if (cmd.take_neck_u) begin
            v_reg <= '0;
        end else if (cmd.scan_issue) begin
            v_reg <= sts.scan_last ? '0 : v_reg + 1'b1;
        end
        if (cmd.aug_start) begin
            cur_reg   <= t_node;
            steps_reg <= '0;
        end else if (cmd.aug_flow_wr) begin
            cur_reg   <= parent_reg;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.take_neck) neck_reg <= lbl_neck;
        if (cmd.aug_flow_rd) begin
            aug_fwd_reg  <= (lbl_dir == DIR_FWD);
            parent_reg   <= lbl_parent;
            aug_addr_reg <= aug_rd_addr;
        end
    end

    assign sts.sweep_last  = &sweep_reg;
    assign sts.cfg_ok      = (9'(source_reg) < n_eff) && (9'(sink_reg) < n_eff)
                             && (source_reg != sink_reg);
    assign sts.queue_empty = (head_reg == tail_reg);
    assign sts.scan_last   = (9'(v_reg) == n_eff - 9'd1);
    assign sts.sink_found  = labelled_reg[t_node];
    assign sts.aug_done    = (cur_reg == s_node) || (steps_reg == (NW+1)'(MAX_NODES));
    assign sts.out_busy    = m_valid_reg && !m_tready;

    assign m_valid   = m_valid_reg;
    assign total_out = result_reg;

    `BFSMF_ASSERT_IMP(a_head_le_tail, aclk, aresetn, 1'b1, head_reg <= tail_reg)
    `BFSMF_ASSERT_NXT(a_init_queue, aclk, aresetn, cmd.search_init,
        (head_reg == '0) && (tail_reg == QW'(1)))
    `BFSMF_ASSERT_IMP(a_aug_bound, aclk, aresetn, cmd.aug_flow_wr,
        steps_reg < (NW+1)'(MAX_NODES))
    `BFSMF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid_reg && !m_tready,
        m_valid_reg && $stable(result_reg))

endmodule

// ===== design/bfs_augmenting_max_flow_unit.sv =====
// Load: one transfer per cycle while idle. Run: the flow store is cleared, then the
// configuration is checked; each search labels nodes from the source over forward and
// backward edges of every dequeued node, and each path found is augmented from the sink
// back by its bottleneck. The result is issued once no path is left, held back while an
// earlier result still waits. Loads are taken while a result waits. Reset: the capacity
// store is swept to zero with s_tready low; configuration writes are taken meanwhile.
module bfs_augmenting_max_flow_unit #(
    parameter int MAX_NODES = bfsmf_pkg::DEF_MAX_NODES,
    parameter int CAP_BITS  = bfsmf_pkg::DEF_CAP_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bfsmf_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bfsmf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // from_node, to_node, capacity, pad
    input  logic                            s_tuser,  // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata   // total flow, pad
);
    import bfsmf_pkg::*;

    ctl_cmd_t           cmd;
    ctl_sts_t           sts;
    logic [TOTAL_W-1:0] total_out;

    bfsmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfsmf_dp #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .from_node (s_tdata[5:0]),
        .to_node   (s_tdata[11:6]),
        .capacity  (s_tdata[27:12]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_valid   (m_tvalid),
        .total_out (total_out)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = {2'b00, total_out};

endmodule
